// ===== rtl/core/rmlp_pkg.sv =====
// Shared types, constants and saturation helpers of the rational-map Lyapunov pixel block.
// Used by rmlp_div and rational_map_lyapunov_pixel; depends on nothing.
`default_nettype none

package rmlp_pkg;

  localparam int unsigned FRAC_BITS_DEF      = 16;
  localparam int unsigned LOG_TABLE_BITS_DEF = 8;

  localparam int unsigned CFG_W   = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MANT_FB = 30;
  localparam int unsigned LN2_SHIFT = 25;
  localparam logic [23:0] LN2_Q24 = 24'd11629080;
  localparam int signed   COLOUR_BIAS = 256;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_A  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 2'd3;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic        dbl;
    logic [31:0] mag;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [67:0] v);
    return (v > 68'sd2147483647) || (v < -68'sd2147483648);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rmlp_div.sv =====
// Bit-serial restoring divider: floor(mag * 2^sh / den), capped and saturated to 32 bits.
// Depends on rmlp_pkg for its request and response structs.
`default_nettype none

module rmlp_div #(
  parameter int unsigned FRAC_BITS = rmlp_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rmlp_pkg::div_req_t req,
  output rmlp_pkg::div_rsp_t rsp
);

  localparam int unsigned ITER_MAX = 32 + 2 * FRAC_BITS;
  localparam int unsigned CNT_W    = $clog2(ITER_MAX + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   last_r;
  logic [31:0]        mag_r;
  logic [63:0]        rem_r;
  logic [63:0]        den_r;
  logic [32:0]        q_r;
  logic               big_r;
  logic               neg_r;
  logic               ovf_r;
  logic signed [31:0] quo_r;

  logic [64:0] rem_sh;
  logic [64:0] rem_dif;
  logic        ge;
  logic [32:0] q_step;
  logic        qbig;
  logic [32:0] cap;
  logic        ovf_fin;
  logic [31:0] quo_fin;

  assign rem_sh  = {rem_r, mag_r[31]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_dif = rem_sh - {1'b0, den_r};
  assign q_step  = {q_r[31:0], ge};
  assign qbig    = big_r | q_r[32] | q_step[32];
  assign cap     = qbig ? 33'h1_0000_0000 : {1'b0, q_step[31:0]};

  // A negative result may reach exactly -2^31; a positive one stops one below 2^31.
  always_comb begin
    if (neg_r) begin
      ovf_fin = cap[32] | (cap[31] & (|cap[30:0]));
      quo_fin = ovf_fin ? 32'h8000_0000 : (32'd0 - cap[31:0]);
    end else begin
      ovf_fin = cap[32] | cap[31];
      quo_fin = ovf_fin ? 32'h7fff_ffff : cap[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        rem_r <= ge ? rem_dif[63:0] : rem_sh[63:0];
        q_r   <= q_step;
        big_r <= big_r | q_r[32];
        mag_r <= {mag_r[30:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == last_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          ovf_r  <= ovf_fin;
          quo_r  <= $signed(quo_fin);
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        mag_r  <= req.mag;
        den_r  <= req.den;
        neg_r  <= req.neg;
        rem_r  <= '0;
        q_r    <= '0;
        big_r  <= 1'b0;
        cnt_r  <= '0;
        last_r <= req.dbl ? CNT_W'(32 + 2 * FRAC_BITS - 1) : CNT_W'(32 + FRAC_BITS - 1);
      end
    end
  end

  assign rsp = '{done: done_r, ovf: ovf_r, quo: quo_r};

endmodule

`default_nettype wire

// ===== rtl/core/rational_map_lyapunov_pixel.sv =====
// Top level of the rational-map Lyapunov pixel block: sequencer, shared multiplier, log unit.
// Depends on rmlp_pkg and instantiates rmlp_div.
//
//  channel  | ports                                  | transfer
//  ---------+----------------------------------------+-----------------------------------
//  input    | start, busy, in_z_re, in_z_im          | edge with start high and busy low
//  result   | out_valid, out_colour_index, out_range_fault | edge ending the out_valid cycle
//  config   | cfg_we, cfg_index, cfg_wdata           | edge with cfg_we high
//
// The bit-serial divider forms both reciprocal components of x in each map step, and r once
// per pixel. Sample steps add a leading-one search and the FRAC_BITS squarings of the log
// unit. Every multiplication in the datapath goes through one registered 32x32 multiplier.
// Reset is synchronous and active low; it returns the sequencer to idle and loads the
// register defaults. The result is shown for exactly one cycle; the receiver cannot stall it.
`default_nettype none

module rational_map_lyapunov_pixel #(
  parameter int unsigned FRAC_BITS      = rmlp_pkg::FRAC_BITS_DEF,
  parameter int unsigned LOG_TABLE_BITS = rmlp_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [31:0]               in_z_re,
  input  logic signed [31:0]               in_z_im,
  output logic                             out_valid,
  output logic signed [15:0]               out_colour_index,
  output logic                             out_range_fault,
  input  logic                             cfg_we,
  input  logic [rmlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rmlp_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int unsigned ST_N = 39;
  localparam int unsigned K_W  = $clog2(FRAC_BITS + 1);
  localparam logic signed [67:0] ONE68 = 68'sd1 <<< FRAC_BITS;

  // Sequencer states. X: reciprocal of x, W: derivative w and |w|^2, L: log,
  // M: map step, P: sample-phase constants.
  typedef enum logic [ST_N-1:0] {
    ST_IDLE = ST_N'(1) << 0,
    ST_RDIV = ST_N'(1) << 1,
    ST_X0   = ST_N'(1) << 2,
    ST_X1   = ST_N'(1) << 3,
    ST_X2   = ST_N'(1) << 4,
    ST_X3   = ST_N'(1) << 5,
    ST_X4   = ST_N'(1) << 6,
    ST_W0   = ST_N'(1) << 7,
    ST_W1   = ST_N'(1) << 8,
    ST_W2   = ST_N'(1) << 9,
    ST_W3   = ST_N'(1) << 10,
    ST_W4   = ST_N'(1) << 11,
    ST_W5   = ST_N'(1) << 12,
    ST_W6   = ST_N'(1) << 13,
    ST_W7   = ST_N'(1) << 14,
    ST_W8   = ST_N'(1) << 15,
    ST_W9   = ST_N'(1) << 16,
    ST_W10  = ST_N'(1) << 17,
    ST_L0   = ST_N'(1) << 18,
    ST_L1   = ST_N'(1) << 19,
    ST_L2   = ST_N'(1) << 20,
    ST_L3   = ST_N'(1) << 21,
    ST_L4   = ST_N'(1) << 22,
    ST_L5   = ST_N'(1) << 23,
    ST_L6   = ST_N'(1) << 24,
    ST_L7   = ST_N'(1) << 25,
    ST_M0   = ST_N'(1) << 26,
    ST_M1   = ST_N'(1) << 27,
    ST_M2   = ST_N'(1) << 28,
    ST_M3   = ST_N'(1) << 29,
    ST_M4   = ST_N'(1) << 30,
    ST_M5   = ST_N'(1) << 31,
    ST_M6   = ST_N'(1) << 32,
    ST_M7   = ST_N'(1) << 33,
    ST_M8   = ST_N'(1) << 34,
    ST_P0   = ST_N'(1) << 35,
    ST_P1   = ST_N'(1) << 36,
    ST_FIN  = ST_N'(1) << 37,
    ST_DONE = ST_N'(1) << 38
  } state_t;

  // Configuration registers.
  logic signed [19:0] coef_a_r;
  logic signed [19:0] coef_b_r;
  logic [11:0]        warmup_r;
  logic [7:0]         sample_r;

  // Sequencer and datapath registers.
  state_t               state_r, state_nxt;
  logic                 samp_r, samp_nxt;
  logic [11:0]          cnt_r, cnt_nxt;
  logic                 fault_r, fault_nxt;
  logic                 den_neg_r, den_neg_nxt;
  logic signed [31:0]   r_r, r_nxt, ra_r, ra_nxt, t_r, t_nxt;
  logic signed [31:0]   xr_r, xr_nxt, xi_r, xi_nxt;
  logic signed [31:0]   ur_r, ur_nxt, ui_r, ui_nxt;
  logic signed [31:0]   pr_r, pr_nxt, pi_r, pi_nxt, qr_r, qr_nxt, qi_r, qi_nxt;
  logic signed [31:0]   sum_r, sum_nxt;
  logic signed [63:0]   h_r, h_nxt;
  logic [63:0]          acc_r, acc_nxt;
  logic [5:0]           p_r, p_nxt;
  logic [31:0]          mant_r, mant_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [K_W-1:0]       k_r, k_nxt;
  logic signed [63:0]   prod_r;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [15:0]   out_colour_r, out_colour_nxt;
  logic                 out_fault_r, out_fault_nxt;

  // Shared multiplier operands and helpers.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_asr;
  logic signed [67:0] pa_ext;
  logic signed [31:0] qm;
  logic               qm_ovf;
  logic signed [31:0] a_s, b_s;
  logic signed [31:0] lg_int;
  logic [LOG_TABLE_BITS-1:0] idx;

  rmlp_pkg::div_req_t div_req;
  rmlp_pkg::div_rsp_t div_rsp;

  assign a_s      = 32'(coef_a_r);
  assign b_s      = 32'(coef_b_r);
  assign prod_asr = prod_r >>> FRAC_BITS;
  assign pa_ext   = 68'(prod_asr);
  assign qm       = rmlp_pkg::sat32(pa_ext);
  assign qm_ovf   = rmlp_pkg::ovf32(pa_ext);
  assign lg_int   = $signed(32'(p_r)) - $signed(32'(2 * FRAC_BITS));
  assign idx      = acc_r[62 -: LOG_TABLE_BITS];
  assign busy     = (state_r != ST_IDLE);

  rmlp_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    logic signed [67:0] e;
    logic signed [67:0] den_e;
    logic signed [67:0] num_e;
    logic signed [67:0] x5;
    logic               flt;
    logic [32:0]        m;

    state_nxt      = state_r;
    samp_nxt       = samp_r;
    cnt_nxt        = cnt_r;
    den_neg_nxt    = den_neg_r;
    r_nxt          = r_r;
    ra_nxt         = ra_r;
    t_nxt          = t_r;
    xr_nxt         = xr_r;
    xi_nxt         = xi_r;
    ur_nxt         = ur_r;
    ui_nxt         = ui_r;
    pr_nxt         = pr_r;
    pi_nxt         = pi_r;
    qr_nxt         = qr_r;
    qi_nxt         = qi_r;
    sum_nxt        = sum_r;
    h_nxt          = h_r;
    acc_nxt        = acc_r;
    p_nxt          = p_r;
    mant_nxt       = mant_r;
    frac_nxt       = frac_r;
    k_nxt          = k_r;
    out_valid_nxt  = 1'b0;
    out_colour_nxt = out_colour_r;
    out_fault_nxt  = out_fault_r;
    mul_a          = '0;
    mul_b          = '0;
    div_req        = '0;
    flt            = fault_r;
    e              = '0;
    x5             = '0;
    m              = prod_r[62:30];
    den_e          = ONE68 - 68'(a_s);
    num_e          = ONE68 - 68'(a_s) - 68'(b_s);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          xr_nxt  = in_z_re;
          xi_nxt  = in_z_im;
          sum_nxt = '0;
          flt     = 1'b0;
          if (den_e == '0) begin
            // Parameter a of one: the map is undefined; the pixel ends with colour zero and the fault flag.
            out_colour_nxt = '0;
            out_fault_nxt  = 1'b1;
            state_nxt      = ST_DONE;
          end else begin
            den_neg_nxt   = den_e < 0;
            div_req.start = 1'b1;
            div_req.neg   = num_e < 0;
            div_req.dbl   = 1'b0;
            div_req.mag   = (num_e < 0) ? 32'(-num_e) : 32'(num_e);
            div_req.den   = (den_e < 0) ? 64'(-den_e) : 64'(den_e);
            state_nxt     = ST_RDIV;
          end
        end
      end
      ST_RDIV: begin
        if (div_rsp.done) begin
          e     = den_neg_r ? -68'(div_rsp.quo) : 68'(div_rsp.quo);
          r_nxt = rmlp_pkg::sat32(e);
          flt   = flt | div_rsp.ovf | rmlp_pkg::ovf32(e);
          samp_nxt = 1'b0;
          cnt_nxt  = warmup_r;
          state_nxt = (warmup_r == '0) ? ST_P0 : ST_X0;
        end
      end
      ST_X0: begin
        if (xr_r == '0 && xi_r == '0) begin
          out_colour_nxt = '0;
          out_fault_nxt  = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          mul_a     = xr_r;
          mul_b     = xr_r;
          state_nxt = ST_X1;
        end
      end
      ST_X1: begin
        acc_nxt   = $unsigned(prod_r);
        mul_a     = xi_r;
        mul_b     = xi_r;
        state_nxt = ST_X2;
      end
      ST_X2: begin
        acc_nxt       = acc_r + $unsigned(prod_r);
        div_req.start = 1'b1;
        div_req.neg   = xr_r[31];
        div_req.dbl   = 1'b1;
        div_req.mag   = xr_r[31] ? 32'(-xr_r) : 32'(xr_r);
        div_req.den   = acc_r + $unsigned(prod_r);
        state_nxt     = ST_X3;
      end
      ST_X3: begin
        if (div_rsp.done) begin
          ur_nxt        = div_rsp.quo;
          flt           = flt | div_rsp.ovf;
          // The imaginary part of 1/x carries the opposite sign of x.im.
          div_req.start = 1'b1;
          div_req.neg   = !xi_r[31] && (xi_r != '0);
          div_req.dbl   = 1'b1;
          div_req.mag   = xi_r[31] ? 32'(-xi_r) : 32'(xi_r);
          div_req.den   = acc_r;
          state_nxt     = ST_X4;
        end
      end
      ST_X4: begin
        if (div_rsp.done) begin
          ui_nxt    = div_rsp.quo;
          flt       = flt | div_rsp.ovf;
          state_nxt = samp_r ? ST_W0 : ST_M0;
        end
      end
      ST_W0: begin
        mul_a     = ur_r;
        mul_b     = ur_r;
        state_nxt = ST_W1;
      end
      ST_W1: begin
        h_nxt     = prod_asr;
        mul_a     = ui_r;
        mul_b     = ui_r;
        state_nxt = ST_W2;
      end
      ST_W2: begin
        e         = 68'(h_r) - pa_ext;
        pr_nxt    = rmlp_pkg::sat32(e);
        flt       = flt | rmlp_pkg::ovf32(e);
        mul_a     = ur_r;
        mul_b     = ui_r;
        state_nxt = ST_W3;
      end
      ST_W3: begin
        h_nxt     = prod_asr;
        mul_a     = ui_r;
        mul_b     = ur_r;
        state_nxt = ST_W4;
      end
      ST_W4: begin
        e         = 68'(h_r) + pa_ext;
        pi_nxt    = rmlp_pkg::sat32(e);
        flt       = flt | rmlp_pkg::ovf32(e);
        mul_a     = ra_r;
        mul_b     = ur_r;
        state_nxt = ST_W5;
      end
      ST_W5: begin
        h_nxt     = 64'(qm);
        flt       = flt | qm_ovf;
        mul_a     = t_r;
        mul_b     = pr_r;
        state_nxt = ST_W6;
      end
      ST_W6: begin
        e         = 68'(h_r) - 68'(qm);
        qr_nxt    = rmlp_pkg::sat32(e);
        flt       = flt | qm_ovf | rmlp_pkg::ovf32(e);
        mul_a     = ra_r;
        mul_b     = ui_r;
        state_nxt = ST_W7;
      end
      ST_W7: begin
        h_nxt     = 64'(qm);
        flt       = flt | qm_ovf;
        mul_a     = t_r;
        mul_b     = pi_r;
        state_nxt = ST_W8;
      end
      ST_W8: begin
        e         = 68'(h_r) - 68'(qm);
        qi_nxt    = rmlp_pkg::sat32(e);
        flt       = flt | qm_ovf | rmlp_pkg::ovf32(e);
        mul_a     = qr_r;
        mul_b     = qr_r;
        state_nxt = ST_W9;
      end
      ST_W9: begin
        acc_nxt   = $unsigned(prod_r);
        mul_a     = qi_r;
        mul_b     = qi_r;
        state_nxt = ST_W10;
      end
      ST_W10: begin
        acc_nxt   = acc_r + $unsigned(prod_r);
        state_nxt = ST_L0;
      end
      ST_L0: begin
        // A zero derivative is treated as the smallest nonzero magnitude.
        if (acc_r == '0) begin
          acc_nxt = 64'd1;
          flt     = 1'b1;
        end
        p_nxt     = 6'd63;
        state_nxt = ST_L1;
      end
      ST_L1: begin
        if (!acc_r[63]) begin
          acc_nxt = {acc_r[62:0], 1'b0};
          p_nxt   = p_r - 1'b1;
        end else begin
          state_nxt = ST_L2;
        end
      end
      ST_L2: begin
        mant_nxt  = (32'd1 << rmlp_pkg::MANT_FB)
                  | (32'(idx) << (rmlp_pkg::MANT_FB - LOG_TABLE_BITS));
        frac_nxt  = '0;
        k_nxt     = K_W'(1);
        state_nxt = ST_L3;
      end
      ST_L3: begin
        mul_a     = $signed(mant_r);
        mul_b     = $signed(mant_r);
        state_nxt = ST_L4;
      end
      ST_L4: begin
        if (m[31]) begin
          mant_nxt = {1'b0, m[31:1]};
          frac_nxt = frac_r | (FRAC_BITS'(1) << (FRAC_BITS - 32'(k_r)));
        end else begin
          mant_nxt = m[31:0];
        end
        if (32'(k_r) == FRAC_BITS) begin
          state_nxt = ST_L5;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_L3;
        end
      end
      ST_L5: begin
        mul_a     = $signed(32'(frac_r));
        mul_b     = $signed(32'(rmlp_pkg::LN2_Q24));
        state_nxt = ST_L6;
      end
      ST_L6: begin
        h_nxt     = prod_r;
        mul_a     = lg_int;
        mul_b     = $signed(32'(rmlp_pkg::LN2_Q24));
        state_nxt = ST_L7;
      end
      ST_L7: begin
        // Integer and fraction parts of log2 are scaled by ln2 separately and recombined.
        e         = 68'(sum_r)
                  + (((68'(prod_r) <<< FRAC_BITS) + 68'(h_r)) >>> rmlp_pkg::LN2_SHIFT);
        sum_nxt   = rmlp_pkg::sat32(e);
        flt       = flt | rmlp_pkg::ovf32(e);
        state_nxt = ST_M0;
      end
      ST_M0: begin
        mul_a     = a_s;
        mul_b     = ur_r;
        state_nxt = ST_M1;
      end
      ST_M1: begin
        e         = ONE68 - 68'(qm);
        pr_nxt    = rmlp_pkg::sat32(e);
        flt       = flt | qm_ovf | rmlp_pkg::ovf32(e);
        mul_a     = a_s;
        mul_b     = ui_r;
        state_nxt = ST_M2;
      end
      ST_M2: begin
        e         = -68'(qm);
        pi_nxt    = rmlp_pkg::sat32(e);
        flt       = flt | qm_ovf | rmlp_pkg::ovf32(e);
        mul_a     = r_r;
        mul_b     = ur_r;
        state_nxt = ST_M3;
      end
      ST_M3: begin
        e         = ONE68 - 68'(qm);
        qr_nxt    = rmlp_pkg::sat32(e);
        flt       = flt | qm_ovf | rmlp_pkg::ovf32(e);
        mul_a     = r_r;
        mul_b     = ui_r;
        state_nxt = ST_M4;
      end
      ST_M4: begin
        e         = -68'(qm);
        qi_nxt    = rmlp_pkg::sat32(e);
        flt       = flt | qm_ovf | rmlp_pkg::ovf32(e);
        mul_a     = pr_r;
        mul_b     = qr_r;
        state_nxt = ST_M5;
      end
      ST_M5: begin
        h_nxt     = prod_asr;
        mul_a     = pi_r;
        mul_b     = qi_r;
        state_nxt = ST_M6;
      end
      ST_M6: begin
        e         = 68'(h_r) - pa_ext;
        xr_nxt    = rmlp_pkg::sat32(e);
        flt       = flt | rmlp_pkg::ovf32(e);
        mul_a     = pr_r;
        mul_b     = qi_r;
        state_nxt = ST_M7;
      end
      ST_M7: begin
        h_nxt     = prod_asr;
        mul_a     = pi_r;
        mul_b     = qr_r;
        state_nxt = ST_M8;
      end
      ST_M8: begin
        e       = 68'(h_r) + pa_ext;
        xi_nxt  = rmlp_pkg::sat32(e);
        flt     = flt | rmlp_pkg::ovf32(e);
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 12'd1) begin
          state_nxt = samp_r ? ST_FIN : ST_P0;
        end else begin
          state_nxt = ST_X0;
        end
      end
      ST_P0: begin
        e         = 68'(r_r) + 68'(a_s);
        ra_nxt    = rmlp_pkg::sat32(e);
        flt       = flt | rmlp_pkg::ovf32(e);
        mul_a     = a_s;
        mul_b     = r_r;
        state_nxt = ST_P1;
      end
      ST_P1: begin
        e        = 68'(qm) <<< 1;
        t_nxt    = rmlp_pkg::sat32(e);
        flt      = flt | qm_ovf | rmlp_pkg::ovf32(e);
        samp_nxt = 1'b1;
        cnt_nxt  = 12'(sample_r);
        state_nxt = (sample_r == '0) ? ST_FIN : ST_X0;
      end
      ST_FIN: begin
        // Division by the fixed-point one truncates toward zero.
        x5 = (68'(sum_r) <<< 2) + 68'(sum_r);
        e  = ((x5 < 0) ? (x5 + (ONE68 - 68'sd1)) : x5) >>> FRAC_BITS;
        e  = e + 68'(rmlp_pkg::COLOUR_BIAS);
        if (e > 68'sd32767) begin
          out_colour_nxt = 16'sh7fff;
          flt            = 1'b1;
        end else if (e < -68'sd32768) begin
          out_colour_nxt = 16'sh8000;
          flt            = 1'b1;
        end else begin
          out_colour_nxt = e[15:0];
        end
        out_fault_nxt = flt;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    fault_nxt = flt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= '0;
      coef_b_r <= '0;
      warmup_r <= 12'd50;
      sample_r <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmlp_pkg::REG_COEF_A:  coef_a_r <= $signed(cfg_wdata);
        rmlp_pkg::REG_COEF_B:  coef_b_r <= $signed(cfg_wdata);
        rmlp_pkg::REG_WARMUP:  warmup_r <= cfg_wdata[11:0];
        rmlp_pkg::REG_SAMPLES: sample_r <= cfg_wdata[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      fault_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fault_r     <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r       <= samp_nxt;
    cnt_r        <= cnt_nxt;
    den_neg_r    <= den_neg_nxt;
    r_r          <= r_nxt;
    ra_r         <= ra_nxt;
    t_r          <= t_nxt;
    xr_r         <= xr_nxt;
    xi_r         <= xi_nxt;
    ur_r         <= ur_nxt;
    ui_r         <= ui_nxt;
    pr_r         <= pr_nxt;
    pi_r         <= pi_nxt;
    qr_r         <= qr_nxt;
    qi_r         <= qi_nxt;
    sum_r        <= sum_nxt;
    h_r          <= h_nxt;
    acc_r        <= acc_nxt;
    p_r          <= p_nxt;
    mant_r       <= mant_nxt;
    frac_r       <= frac_nxt;
    k_r          <= k_nxt;
    prod_r       <= mul_a * mul_b;
    out_colour_r <= out_colour_nxt;
    out_fault_r  <= out_fault_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_colour_index = out_colour_r;
  assign out_range_fault  = out_fault_r;

endmodule

`default_nettype wire

// ===== rtl/core/rmlp_chk.sv =====
// Port-level checker for rational_map_lyapunov_pixel, attached by the bind at the end.
// Depends only on the top level's port names.
`default_nettype none

module rmlp_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // An accepted pixel keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted pixel did not make the block busy");

  // A result is only shown once the block has gone idle.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Each pixel ends with a result: out_valid is high when busy falls.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("pixel finished without a result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

endmodule

bind rational_map_lyapunov_pixel rmlp_chk u_rmlp_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid)
);

`default_nettype wire
